FILE: rtl/sfq_pkg.sv
// Shared types, codes and defaults for the searchable FIFO queue.
package sfq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;

  // Command codes carried in the request
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_SEARCH  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_DUMP    = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]                operation;
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [FIELD_W-1:0] entry_value;
    logic                      last;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    push;
    logic    replace;
    logic    remove;
    logic    rotate;
    logic    emit;
    status_t emit_status;
    logic    emit_entry;
    logic    emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       found;
    logic       dump_last;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: rtl/sfq_ctrl.sv
// Command sequencer for the searchable FIFO queue.
module sfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_op,
  output logic               in_ready,
  input  sfq_pkg::dp_stat_t  stat,
  output sfq_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_RESOLVE = 3'b010,
    S_DUMP    = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   op_ok;

  // Codes above dump are dropped without a result
  assign op_ok    = (in_op <= sfq_pkg::OP_DUMP);
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && op_ok) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_op == sfq_pkg::OP_DUMP) ? S_DUMP : S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
          if (stat.op == sfq_pkg::OP_PUSH) begin
            if (stat.full) begin
              cmd.emit_status = sfq_pkg::ST_FULL;
            end else begin
              cmd.push        = 1'b1;
              cmd.emit_status = sfq_pkg::ST_OK;
            end
          end else if (stat.empty) begin
            cmd.emit_status = sfq_pkg::ST_EMPTY;
          end else if (!stat.found) begin
            cmd.emit_status = sfq_pkg::ST_NOT_FOUND;
          end else begin
            cmd.emit_status = sfq_pkg::ST_OK;
            cmd.replace     = (stat.op == sfq_pkg::OP_REPLACE);
            cmd.remove      = (stat.op == sfq_pkg::OP_REMOVE);
          end
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.empty) begin
            cmd.emit_status = sfq_pkg::ST_EMPTY;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.emit_status = sfq_pkg::ST_OK;
            cmd.emit_entry  = 1'b1;
            cmd.rotate      = 1'b1;
            cmd.emit_last   = stat.dump_last;
            if (stat.dump_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/sfq_datapath.sv
// Entry cells, parallel match, count and result register of the queue.
module sfq_datapath #(
  parameter int DEPTH = sfq_pkg::DEPTH_DEF,
  parameter int WIDTH = sfq_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfq_pkg::in_req_t  in_data,
  input  sfq_pkg::dp_cmd_t  cmd,
  output sfq_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output sfq_pkg::out_rsp_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  entry_r   [DEPTH];
  logic [WIDTH-1:0]  entry_nxt [DEPTH];
  logic [WIDTH-1:0]  shift_src [DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     dump_idx_r;
  logic [2:0]        op_r;
  logic [WIDTH-1:0]  nv_r;
  logic [WIDTH-1:0]  key_w;
  logic [DEPTH-1:0]  valid_mask;
  logic [DEPTH-1:0]  match_r;
  logic [DEPTH-1:0]  first_hit;
  logic [DEPTH-1:0]  shift_mask;
  logic              out_valid_r;
  sfq_pkg::out_rsp_t out_r;

  // Key in storage format
  assign key_w = WIDTH'(in_data.key);

  // Occupied slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_mask[i] = (CW'(i) < count_r);
    end
  end

  // Neighbor feeding each cell when the queue closes up or rotates
  for (genvar g = 0; g < DEPTH; g++) begin : g_src
    if (g == DEPTH - 1) begin : g_end
      assign shift_src[g] = entry_r[g];
    end else begin : g_mid
      assign shift_src[g] = entry_r[g + 1];
    end
  end

  // First match from the head, and the slots at and past it
  assign first_hit  = match_r & (~match_r + DEPTH'(1));
  assign shift_mask = ~(first_hit - DEPTH'(1));

  // Cell updates
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      if (cmd.push && (CW'(i) == count_r)) begin
        entry_nxt[i] = nv_r;
      end else if (cmd.replace && first_hit[i]) begin
        entry_nxt[i] = nv_r;
      end else if (cmd.remove && shift_mask[i]) begin
        entry_nxt[i] = shift_src[i];
      end else if (cmd.rotate) begin
        entry_nxt[i] = (CW'(i + 1) == count_r) ? entry_r[0] : shift_src[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Request capture and parallel compare
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_data.operation;
      nv_r <= WIDTH'(in_data.new_value);
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= valid_mask[i] && (entry_r[i] == key_w);
      end
    end
  end

  // Dump position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dump_idx_r <= '0;
    end else if (cmd.rotate) begin
      dump_idx_r <= dump_idx_r + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status      <= cmd.emit_status;
      out_r.entry_value <= cmd.emit_entry ? sfq_pkg::FIELD_W'($signed(entry_r[0])) : '0;
      out_r.last        <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller
  assign stat.op        = op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.found     = |match_r;
  assign stat.dump_last = ((dump_idx_r + CW'(1)) == count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken result");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |=> ((count_r + CW'(1)) == $past(count_r)))
    else $error("remove did not shrink the queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r != CW'(DEPTH)))
    else $error("push into a full queue");

  a_rotate_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |-> (count_r != '0) && (dump_idx_r < count_r))
    else $error("dump step outside the queue");
`endif

endmodule

FILE: rtl/searchable_fifo_queue_top.sv
// Top level of the searchable FIFO queue: controller plus datapath.
//
// Usage:
//  - Requests arrive on in_valid/in_ready/in_data (operation, key, new_value).
//    Operations: push, search, replace first match, remove first match, dump.
//    Unused operation codes are taken and dropped with no result.
//  - Results leave on out_valid/out_ready/out_data (status, entry_value, last).
//    Every command except dump gives one result with last set; dump gives one
//    result per entry, head first, last on the tail (one empty result if none).
//  - Timing: a non-dump result is loaded into the output register from the
//    resolve state, once that register is free. No new request is taken
//    until a command has loaded its last result. A dump loads one entry
//    per cycle while the output register is free. The compare across all
//    slots is registered at request time, and the first-match pick and
//    update run in the resolve state once the output register is free.
//  - Reset (rst_n low, synchronous) empties the queue and drops any pending
//    result. Slot contents are not cleared; only occupied slots are ever read.
//  - A stalled receiver holds the result register. One more request can still
//    be taken, but its result (or the next dump entry) waits until the
//    register frees, and no further request is taken meanwhile.
module searchable_fifo_queue_top #(
  parameter int DEPTH = sfq_pkg::DEPTH_DEF,
  parameter int WIDTH = sfq_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfq_pkg::out_rsp_t out_data
);

  sfq_pkg::dp_cmd_t  cmd;
  sfq_pkg::dp_stat_t stat;

  sfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfq_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
